// ----- hdl/gregorian_date_decrement_core_defines.svh -----
// Assertion macros shared by the date decrement checker.
`ifndef GREGORIAN_DATE_DECREMENT_CORE_DEFINES_SVH
`define GREGORIAN_DATE_DECREMENT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GDD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("date decrement check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("date decrement check failed");

`endif

// ----- hdl/gdd_pkg.sv -----
// Shared types, codes and calendar helpers for the date decrement core.
`default_nettype none

package gdd_pkg;

  localparam int YEAR_WIDTH = 16;
  localparam int FUNC_W     = 3;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int COUNT_W    = 15;
  // Week mode runs up to seven times the count in day steps.
  localparam int CNT_W      = COUNT_W + 3;

  localparam logic [FUNC_W-1:0] FUNC_DAYS      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WEEKS     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MONTHS    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_YEARS     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DECADES   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CENTURY   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_MILLENNIUM = 3'd6;

  typedef struct packed {
    logic load;
    logic res_shift;
    logic step;
    logic out_load;
  } gdd_cmd_t;

  typedef struct packed {
    logic iter_req;
    logic res_done;
    logic cnt_zero;
  } gdd_sts_t;

  // 2^w mod 25, evaluated at elaboration only.
  function automatic int pow2_mod25(int w);
    int r;
    r = 1;
    for (int i = 0; i < w; i++) begin
      r = (r * 2) % 25;
    end
    return r;
  endfunction

  // Length of a month; anything outside 1..12 has no days.
  function automatic logic [DAY_W-1:0] days_of(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gdd_ctrl.sv -----
// Sequencer for the date decrement core: load, residue, step, hand off.
`default_nettype none

module gdd_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  input  wire gdd_pkg::gdd_sts_t sts_i,
  output gdd_pkg::gdd_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RES    = 2'd1;
  localparam logic [1:0] ST_STEP   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.iter_req ? ST_RES : ST_FINISH;
        end
      end
      ST_RES: begin
        cmd_o.res_shift = 1'b1;
        if (sts_i.res_done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts_i.cnt_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        // wait until the output word slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/gdd_datapath.sv -----
// Date registers, step counter, year mod-25 residue and output register.
`default_nettype none

module gdd_datapath #(
  parameter int YEAR_WIDTH = gdd_pkg::YEAR_WIDTH
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire gdd_pkg::gdd_cmd_t            cmd_i,
  output gdd_pkg::gdd_sts_t                 sts_o,
  input  wire [gdd_pkg::FUNC_W-1:0]         func_i,
  input  wire [YEAR_WIDTH-1:0]              year_i,
  input  wire [gdd_pkg::MONTH_W-1:0]        month_i,
  input  wire [gdd_pkg::DAY_W-1:0]          day_i,
  input  wire [gdd_pkg::COUNT_W-1:0]        count_i,
  output logic [YEAR_WIDTH-1:0]             year_o,
  output logic [gdd_pkg::MONTH_W-1:0]       month_o,
  output logic [gdd_pkg::DAY_W-1:0]         day_o
);

  localparam int WIDE   = (YEAR_WIDTH > 19) ? YEAR_WIDTH : 19;
  localparam int K25    = gdd_pkg::pow2_mod25(YEAR_WIDTH);
  localparam int YP_W   = 40;
  localparam int FOLD_W = 13;
  // ceil(2^17 / 25): exact quotient for any folded value below 2^13
  localparam logic [FOLD_W-1:0] RECIP_25 = 13'd5243;
  // residue of a negative year that is a multiple of 25
  localparam logic [4:0] RES_NEG  = 5'(K25);
  // residue of the all-ones year reached when zero wraps
  localparam logic [4:0] RES_WRAP = 5'((K25 + 24) % 25);

  logic [gdd_pkg::FUNC_W-1:0]  mode_q;
  logic [YEAR_WIDTH-1:0]       year_q, year_d;
  logic [gdd_pkg::MONTH_W-1:0] month_q, month_d;
  logic [gdd_pkg::DAY_W-1:0]   day_q, day_d;
  logic [gdd_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [4:0]                  res_q, res_d;
  logic                        res_ph_q;
  logic [FOLD_W-1:0]           fold_q, fold_d;

  logic [YEAR_WIDTH-1:0]       out_year_q;
  logic [gdd_pkg::MONTH_W-1:0] out_month_q;
  logic [gdd_pkg::DAY_W-1:0]   out_day_q;

  logic [WIDE-1:0]             sub_wide;
  logic [gdd_pkg::CNT_W-1:0]   cnt_load;
  logic [YP_W-1:0]             year_pad;
  logic [2*FOLD_W-1:0]         quot_prod;
  logic [8:0]                  quot;
  logic [FOLD_W-1:0]           fold_rem;
  logic                        z25, leap;
  logic [gdd_pkg::MONTH_W-1:0] month_dec;
  logic [YEAR_WIDTH-1:0]       year_dec;
  logic [4:0]                  res_dec;

  // Subtrahend for the year-only modes.
  always_comb begin
    case (func_i)
      gdd_pkg::FUNC_YEARS:      sub_wide = WIDE'(count_i);
      gdd_pkg::FUNC_DECADES:    sub_wide = WIDE'({count_i, 3'b000}) + WIDE'({count_i, 1'b0});
      gdd_pkg::FUNC_CENTURY:    sub_wide = WIDE'(100);
      gdd_pkg::FUNC_MILLENNIUM: sub_wide = WIDE'(1000);
      default:                  sub_wide = '0;
    endcase
  end

  assign cnt_load = (func_i == gdd_pkg::FUNC_WEEKS)
                    ? ({count_i, 3'b000} - {3'b000, count_i})
                    : {3'b000, count_i};

  assign sts_o.iter_req = ((func_i == gdd_pkg::FUNC_DAYS) || (func_i == gdd_pkg::FUNC_WEEKS) ||
                           (func_i == gdd_pkg::FUNC_MONTHS)) && (count_i != '0);
  assign sts_o.res_done = !res_ph_q;
  assign sts_o.cnt_zero = (cnt_q == '0);

  // 1024 is -1 mod 25: alternate the 10-bit chunks, offset by 2050 to stay positive
  assign year_pad  = YP_W'(year_q);
  assign fold_d    = FOLD_W'(year_pad[9:0]) + FOLD_W'(year_pad[29:20])
                   + (FOLD_W'(1025) - FOLD_W'(year_pad[19:10]))
                   + (FOLD_W'(1025) - FOLD_W'(year_pad[39:30]));
  assign quot_prod = fold_q * RECIP_25;
  assign quot      = quot_prod[25:17];
  assign fold_rem  = fold_q - FOLD_W'({quot, 4'b0000}) - FOLD_W'({quot, 3'b000})
                   - FOLD_W'(quot);

  // Leap rule on the signed year: multiple of 400, or of 4 but not of 100.
  assign z25  = year_q[YEAR_WIDTH-1] ? (res_q == RES_NEG) : (res_q == 5'd0);
  assign leap = z25 ? (year_q[3:0] == 4'd0) : (year_q[1:0] == 2'd0);

  assign month_dec = month_q - 4'd1;
  assign year_dec  = year_q - YEAR_WIDTH'(1);
  assign res_dec   = (year_q == '0) ? RES_WRAP : ((res_q == 5'd0) ? 5'd24 : res_q - 5'd1);

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      year_d  = year_i - sub_wide[YEAR_WIDTH-1:0];
      month_d = month_i;
      day_d   = day_i;
      cnt_d   = cnt_load;
      res_d   = 5'd0;
    end else if (cmd_i.res_shift) begin
      if (!res_ph_q) begin
        res_d = fold_rem[4:0];
      end
    end else if (cmd_i.step) begin
      cnt_d = cnt_q - 1'b1;
      if (mode_q == gdd_pkg::FUNC_MONTHS) begin
        if (month_q == 4'd1) begin
          year_d  = year_dec;
          res_d   = res_dec;
          month_d = 4'd12;
        end else begin
          month_d = month_dec;
        end
        // year only moves when landing in December, so the leap flag stays valid
        if (day_q == 5'd1) begin
          day_d = gdd_pkg::days_of(month_d, leap);
        end
      end else if (day_q == 5'd1) begin
        if (month_q == 4'd1) begin
          year_d  = year_dec;
          res_d   = res_dec;
          month_d = 4'd12;
          day_d   = 5'd31;
        end else begin
          month_d = month_dec;
          day_d   = gdd_pkg::days_of(month_dec, leap);
        end
      end else begin
        day_d = day_q - 5'd1;
      end
    end
  end

  // The residue pass first folds the year, then reduces the fold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ph_q <= 1'b0;
    end else if (cmd_i.load) begin
      res_ph_q <= 1'b1;
    end else if (cmd_i.res_shift) begin
      res_ph_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= func_i;
    end
    if (cmd_i.res_shift && res_ph_q) begin
      fold_q <= fold_d;
    end
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    if (cmd_i.out_load) begin
      out_year_q  <= year_q;
      out_month_q <= month_q;
      out_day_q   <= day_q;
    end
  end

  assign year_o  = out_year_q;
  assign month_o = out_month_q;
  assign day_o   = out_day_q;

endmodule

`default_nettype wire

// ----- hdl/gregorian_date_decrement_core.sv -----
// Top level of the Gregorian date decrement core.
// Moves a date back by a count of days, weeks, months, years or decades, or by one
// century or millennium, with the Gregorian leap rule and a year that wraps at
// YEAR_WIDTH bits. One word is in work at a time. Year, decade, century and
// millennium words, a zero count and the unused mode go from accept to the finish
// state and then to the result word. Day, week and month words first run a
// residue pass that folds the year and reduces it mod 25 for the leap test, then
// one day or month is stepped back each cycle, count times (seven times the count
// for weeks), before the finish state. The result sits in an output register, so
// a new word is taken while the previous result still waits for the sink.
`default_nettype none

module gregorian_date_decrement_core #(
  parameter int YEAR_WIDTH = gdd_pkg::YEAR_WIDTH
) (
  input  wire clk_i,
  input  wire rst_ni,
  input  wire s_tvalid_i,
  output logic s_tready_o,
  // func, year_in, month_in, day_in, step_count (low bit up), zero padded
  input  wire [((gdd_pkg::FUNC_W + YEAR_WIDTH + gdd_pkg::MONTH_W + gdd_pkg::DAY_W +
                 gdd_pkg::COUNT_W + 7) / 8) * 8 - 1:0] s_tdata_i,
  output logic m_tvalid_o,
  input  wire m_tready_i,
  // year_out, month_out, day_out (low bit up), zero padded
  output logic [((YEAR_WIDTH + gdd_pkg::MONTH_W + gdd_pkg::DAY_W + 7) / 8) * 8 - 1:0]
               m_tdata_o
);

  localparam int YEAR_LO  = gdd_pkg::FUNC_W;
  localparam int MONTH_LO = YEAR_LO + YEAR_WIDTH;
  localparam int DAY_LO   = MONTH_LO + gdd_pkg::MONTH_W;
  localparam int COUNT_LO = DAY_LO + gdd_pkg::DAY_W;
  localparam int OUT_W    = YEAR_WIDTH + gdd_pkg::MONTH_W + gdd_pkg::DAY_W;
  localparam int M_W      = ((OUT_W + 7) / 8) * 8;

  gdd_pkg::gdd_cmd_t           cmd;
  gdd_pkg::gdd_sts_t           sts;
  logic [YEAR_WIDTH-1:0]       year_out;
  logic [gdd_pkg::MONTH_W-1:0] month_out;
  logic [gdd_pkg::DAY_W-1:0]   day_out;

  gdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gdd_datapath #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .func_i  (s_tdata_i[gdd_pkg::FUNC_W-1:0]),
    .year_i  (s_tdata_i[MONTH_LO-1:YEAR_LO]),
    .month_i (s_tdata_i[DAY_LO-1:MONTH_LO]),
    .day_i   (s_tdata_i[COUNT_LO-1:DAY_LO]),
    .count_i (s_tdata_i[COUNT_LO+gdd_pkg::COUNT_W-1:COUNT_LO]),
    .year_o  (year_out),
    .month_o (month_out),
    .day_o   (day_out)
  );

  assign m_tdata_o = M_W'({day_out, month_out, year_out});

endmodule

`default_nettype wire

// ----- hdl/gdd_checker.sv -----
// Port-level checks for the date decrement core, bound to the top level.
`default_nettype none
`include "gregorian_date_decrement_core_defines.svh"

module gdd_checker #(
  parameter int YEAR_WIDTH = gdd_pkg::YEAR_WIDTH
) (
  input wire clk_i,
  input wire rst_ni,
  input wire s_tvalid_i,
  input wire s_tready_o,
  input wire m_tvalid_o,
  input wire m_tready_i,
  input wire [((YEAR_WIDTH + gdd_pkg::MONTH_W + gdd_pkg::DAY_W + 7) / 8) * 8 - 1:0]
             m_tdata_o
);

  // a stalled result word holds
  `GDD_ASSERT_NEXT(a_out_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o))
  // one word in work at a time
  `GDD_ASSERT_NEXT(a_busy_after_accept, s_tvalid_i && s_tready_o, !s_tready_o)
  // a result only appears after the core was busy on it
  `GDD_ASSERT(a_result_from_work, $rose(m_tvalid_o), $past(!s_tready_o))

endmodule

bind gregorian_date_decrement_core gdd_checker #(
  .YEAR_WIDTH (YEAR_WIDTH)
) u_gdd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

`default_nettype wire

// ----- dv/gregorian_date_decrement_core_tb.sv -----
// Self-checking stream testbench for the Gregorian date decrement core.
`timescale 1ns / 1ps

module gregorian_date_decrement_core_tb;

  localparam int YEAR_WIDTH = gdd_pkg::YEAR_WIDTH;
  localparam int FUNC_W     = gdd_pkg::FUNC_W;
  localparam int MONTH_W    = gdd_pkg::MONTH_W;
  localparam int DAY_W      = gdd_pkg::DAY_W;
  localparam int COUNT_W    = gdd_pkg::COUNT_W;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  typedef struct packed {
    logic [YEAR_WIDTH-1:0] year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
  } date_t;

  typedef struct packed {
    logic                  hold;
    logic [FUNC_W-1:0]     func;
    date_t                 start;
    logic [COUNT_W-1:0]    count;
  } date_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [47:0] s_tdata_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;

  date_cmd_t date_cmds[$];
  date_t     due_dates[$];
  date_cmd_t drv_cmd = '0;
  logic      in_fire = 1'b0;
  logic      calm = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        fail_count = 0;
  int        n_checked = 0;
  int        mode_seen[8];

  gregorian_date_decrement_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_leap(logic [YEAR_WIDTH-1:0] y);
    int s;
    s = int'($signed(y));
    return (s % 400 == 0) || ((s % 4 == 0) && (s % 100 != 0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [YEAR_WIDTH-1:0] y,
                                                 logic [MONTH_W-1:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     return 5'd30;
      4'd2:                                        return is_leap(y) ? 5'd29 : 5'd28;
      default:                                     return 5'd0;
    endcase
  endfunction

  function automatic date_t prev_day(date_t t);
    if (t.day == 5'd1) begin
      if (t.month == 4'd1) begin
        t.year  = t.year - 1'b1;
        t.month = 4'd12;
        t.day   = 5'd31;
      end else begin
        t.month = t.month - 1'b1;
        t.day   = month_len(t.year, t.month);
      end
    end else begin
      t.day = t.day - 1'b1;
    end
    return t;
  endfunction

  // Keep the day unless it was the first; never clamp.
  function automatic date_t prev_month(date_t t);
    if (t.month == 4'd1) begin
      t.year  = t.year - 1'b1;
      t.month = 4'd12;
    end else begin
      t.month = t.month - 1'b1;
    end
    if (t.day == 5'd1) t.day = month_len(t.year, t.month);
    return t;
  endfunction

  function automatic date_t step_back_date(date_cmd_t c);
    date_t t;
    int    n;
    t = c.start;
    n = int'(c.count);
    case (c.func)
      gdd_pkg::FUNC_DAYS:       for (int i = 0; i < n; i++) t = prev_day(t);
      gdd_pkg::FUNC_WEEKS:      for (int i = 0; i < n * 7; i++) t = prev_day(t);
      gdd_pkg::FUNC_MONTHS:     for (int i = 0; i < n; i++) t = prev_month(t);
      gdd_pkg::FUNC_YEARS:      t.year = t.year - YEAR_WIDTH'(n);
      gdd_pkg::FUNC_DECADES:    t.year = t.year - YEAR_WIDTH'(n * 10);
      gdd_pkg::FUNC_CENTURY:    t.year = t.year - YEAR_WIDTH'(100);
      gdd_pkg::FUNC_MILLENNIUM: t.year = t.year - YEAR_WIDTH'(1000);
      default:                  ;
    endcase
    return t;
  endfunction

  function automatic int draw_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic add_cmd(logic [FUNC_W-1:0] f, logic [YEAR_WIDTH-1:0] y,
                         logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d,
                         logic [COUNT_W-1:0] n, logic hold = 1'b0);
    date_cmd_t c;
    c.hold  = hold;
    c.func  = f;
    c.start = '{year: y, month: m, day: d};
    c.count = n;
    date_cmds.push_back(c);
  endtask

  // Sender: present the next word once the current one is taken.
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = s_tvalid_i && !in_fire;
    if (rst_ni && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (date_cmds.size() != 0 &&
                   (!date_cmds[0].hold || due_dates.size() == 0)) begin
        drv_cmd   <= date_cmds[0];
        s_tdata_i <= {5'b0, date_cmds[0].count, date_cmds[0].start.day,
                      date_cmds[0].start.month, date_cmds[0].start.year,
                      date_cmds[0].func};
        void'(date_cmds.pop_front());
        nxt_valid = 1'b1;
        gap_left  <= draw_pause();
      end
    end
    s_tvalid_i <= nxt_valid;
  end

  // Sink: stall at random, with calm stretches.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left <= draw_pause();
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    date_t want;
    date_t got;
    in_fire <= s_tvalid_i && s_tready_o;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = '{year: m_tdata_o[15:0], month: m_tdata_o[19:16], day: m_tdata_o[24:20]};
      if (due_dates.size() == 0) begin
        $error("result word with no date due: %h", m_tdata_o);
        fail_count++;
      end else begin
        want = due_dates.pop_front();
        n_checked++;
        if (n_checked % 100 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (got.year !== want.year) begin
          $error("year_out: expected %0d, got %0d", $signed(want.year), $signed(got.year));
          fail_count++;
        end
        if (got.month !== want.month) begin
          $error("month_out: expected %0d, got %0d", want.month, got.month);
          fail_count++;
        end
        if (got.day !== want.day) begin
          $error("day_out: expected %0d, got %0d", want.day, got.day);
          fail_count++;
        end
      end
    end
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      due_dates.push_back(step_back_date(drv_cmd));
      mode_seen[drv_cmd.func]++;
    end
  end

  initial begin
    logic [FUNC_W-1:0]     f;
    logic [YEAR_WIDTH-1:0] y;
    logic [MONTH_W-1:0]    m;
    logic [DAY_W-1:0]      d;
    logic [DAY_W-1:0]      len;
    logic [COUNT_W-1:0]    n;
    int                    r;

    // Zero count, year underflow, leap rule for positive and negative years.
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd2024, 4'd6, 5'd15, 15'd0);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd0, 4'd1, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'h8000, 4'd1, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd2000, 4'd3, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd1900, 4'd3, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd2024, 4'd3, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'(-400), 4'd3, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'(-100), 4'd3, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'(-4), 4'd3, 5'd1, 15'd1);
    // Months outside 1..12 and invalid days.
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd7, 4'd0, 5'd1, 15'd2);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd7, 4'd13, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd7, 4'd5, 5'd0, 15'd1);
    add_cmd(gdd_pkg::FUNC_DAYS, 16'd7, 4'd2, 5'd31, 15'd3);
    add_cmd(gdd_pkg::FUNC_MONTHS, 16'd7, 4'd0, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_MONTHS, 16'd7, 4'd15, 5'd31, 15'd2);
    // Month steps: end-of-month from the first, no clamp otherwise; one week step.
    add_cmd(gdd_pkg::FUNC_MONTHS, 16'd2024, 4'd3, 5'd1, 15'd1);
    add_cmd(gdd_pkg::FUNC_MONTHS, 16'd2023, 4'd3, 5'd31, 15'd1);
    add_cmd(gdd_pkg::FUNC_MONTHS, 16'd0, 4'd1, 5'd31, 15'd1);
    add_cmd(gdd_pkg::FUNC_WEEKS, 16'd2024, 4'd3, 5'd5, 15'd1);
    // Full counts and whole-year modes at the extremes.
    add_cmd(gdd_pkg::FUNC_DAYS, 16'h7FFF, 4'd12, 5'd31, 15'h7FFF);
    add_cmd(gdd_pkg::FUNC_WEEKS, 16'h7FFF, 4'd12, 5'd31, 15'h7FFF);
    add_cmd(gdd_pkg::FUNC_MONTHS, 16'h0001, 4'd1, 5'd1, 15'h7FFF);
    add_cmd(gdd_pkg::FUNC_YEARS, 16'h8000, 4'd12, 5'd31, 15'h7FFF);
    add_cmd(gdd_pkg::FUNC_DECADES, 16'h8000, 4'd1, 5'd1, 15'h7FFF);
    add_cmd(gdd_pkg::FUNC_CENTURY, 16'h8000, 4'd2, 5'd29, 15'h7FFF);
    add_cmd(gdd_pkg::FUNC_MILLENNIUM, 16'h83E7, 4'd7, 5'd4, 15'd0);
    add_cmd(FUNC_UNUSED, 16'hFFFF, 4'd15, 5'd31, 15'h7FFF);

    for (int k = 0; k < 1450; k++) begin
      r = $urandom_range(0, 99);
      if (r < 20)      f = gdd_pkg::FUNC_DAYS;
      else if (r < 32) f = gdd_pkg::FUNC_WEEKS;
      else if (r < 50) f = gdd_pkg::FUNC_MONTHS;
      else if (r < 62) f = gdd_pkg::FUNC_YEARS;
      else if (r < 74) f = gdd_pkg::FUNC_DECADES;
      else if (r < 82) f = gdd_pkg::FUNC_CENTURY;
      else if (r < 90) f = gdd_pkg::FUNC_MILLENNIUM;
      else             f = FUNC_UNUSED;

      r = $urandom_range(0, 99);
      if (r < 40)      y = 16'($urandom_range(0, 65535));
      else if (r < 55) y = 16'($urandom_range(16'h8000, 16'h8040));
      else if (r < 70) y = 16'($urandom_range(16'h7FC0, 16'h7FFF));
      else             y = 16'($urandom_range(0, 6000) - 3000);

      if ($urandom_range(0, 99) < 8) m = 4'($urandom_range(0, 15));
      else                           m = 4'($urandom_range(1, 12));

      len = month_len(y, m);
      r = $urandom_range(0, 99);
      if (r < 10 || len == 5'd0) d = 5'($urandom_range(0, 31));
      else if (r < 35)           d = 5'd1;
      else if (r < 50)           d = len;
      else                       d = 5'($urandom_range(1, len));

      // Stepped modes walk back one unit at a time; keep their counts mostly small.
      r = $urandom_range(0, 99);
      if (f == gdd_pkg::FUNC_DAYS || f == gdd_pkg::FUNC_MONTHS) begin
        if (r < 70)      n = 15'($urandom_range(0, 40));
        else if (r < 95) n = 15'($urandom_range(0, 400));
        else             n = 15'($urandom_range(0, 1500));
      end else if (f == gdd_pkg::FUNC_WEEKS) begin
        if (r < 70)      n = 15'($urandom_range(0, 6));
        else if (r < 95) n = 15'($urandom_range(0, 60));
        else             n = 15'($urandom_range(0, 214));
      end else begin
        n = (r < 10) ? 15'd0 : 15'($urandom_range(0, 32767));
      end

      add_cmd(f, y, m, d, n, (k % 300 == 0));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (date_cmds.size() != 0 || s_tvalid_i || due_dates.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (due_dates.size() != 0) begin
      $error("%0d dates still due at end of run", due_dates.size());
      fail_count++;
    end

    $display("Checked %0d dates: days %0d, weeks %0d, months %0d, years %0d, decades %0d,",
             n_checked, mode_seen[gdd_pkg::FUNC_DAYS], mode_seen[gdd_pkg::FUNC_WEEKS],
             mode_seen[gdd_pkg::FUNC_MONTHS], mode_seen[gdd_pkg::FUNC_YEARS],
             mode_seen[gdd_pkg::FUNC_DECADES]);
    $display("  century %0d, millennium %0d, unused mode %0d; %0d mismatches.",
             mode_seen[gdd_pkg::FUNC_CENTURY], mode_seen[gdd_pkg::FUNC_MILLENNIUM],
             mode_seen[FUNC_UNUSED], fail_count);
    if (fail_count == 0) begin
      $display("gregorian_date_decrement_core_tb: PASS");
    end else begin
      $display("gregorian_date_decrement_core_tb: FAIL");
    end
    $finish;
  end

  // Full-count week words alone step back seven times the largest count; allow ample margin.
  initial begin
    #80_000_000;
    $display("gregorian_date_decrement_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/gdd_pkg.sv
hdl/gdd_ctrl.sv
hdl/gdd_datapath.sv
hdl/gregorian_date_decrement_core.sv
hdl/gdd_checker.sv
dv/gregorian_date_decrement_core_tb.sv
